// ===== hw/rtl/quad_float_round_to_integer_macros.svh =====
// Assertion macros shared by the decode, align and finish RTL files
`ifndef QUAD_FLOAT_ROUND_TO_INTEGER_MACROS_SVH
`define QUAD_FLOAT_ROUND_TO_INTEGER_MACROS_SVH
// Implication checked on every clock, masked in reset
`define QFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define QFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/qfr_pkg.sv =====
// ----------------------------------------------------------------------------
// qfr_pkg
// Types and constants for the binary128 round-to-integer pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package qfr_pkg;
  localparam int unsigned Bias   = 16383;
  localparam logic [14:0] ExpMax = 15'h7fff;

  typedef enum logic [1:0] {
    REQ_TRUNC   = 2'd0,
    REQ_AWAY    = 2'd1,
    REQ_INT_RM  = 2'd2,
    REQ_INT_AWY = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RTZ = 2'd1,
    RM_RUP = 2'd2,
    RM_RDN = 2'd3
  } rnd_mode_e;

  // stage 1 -> stage 2: decoded operand
  typedef struct packed {
    logic         vld;
    logic         is_int;
    logic         away;
    rnd_mode_e    mode;
    logic         neg;
    logic         special;   // exp all ones
    logic         big;       // already integral / saturating
    logic         tiny;      // exp < bias
    logic         near_half; // exp == bias-1
    logic         frac_nz;
    logic         exp_nz;
    logic [6:0]   f;         // 112 - unbiased exponent, 1..112
    logic [127:0] x;
  } dec_t;

  // stage 2 -> stage 3: masked value and rounding info
  typedef struct packed {
    logic         vld;
    logic         is_int;
    logic         neg;
    logic         pass;      // res = x (float path)
    logic         zero_res;  // res = signed zero / one
    logic         one_res;
    logic         sat;
    logic         inc;       // float: add bit
    logic [127:0] x;
    logic [127:0] addv;
    logic [127:0] mask;
    logic [31:0]  ipart;
    logic         ip_big;
    logic         half;
    logic         sticky;
    rnd_mode_e    mode;
    logic         away;
  } mid_t;
endpackage
`default_nettype wire

// ===== hw/rtl/qfr_decode.sv =====
// ----------------------------------------------------------------------------
// qfr_decode
// Stage 1: field split and exponent classification.
// ----------------------------------------------------------------------------
`default_nettype none
module qfr_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [1:0]       mode_i,
  input  wire logic [127:0]     x_i,
  output qfr_pkg::dec_t         dec_o
);
  import qfr_pkg::*;
  `include "quad_float_round_to_integer_macros.svh"

  logic [14:0] ex;
  dec_t d_d, d_q;
  logic [15:0] ub;
  logic        vld_q;

  assign ex = x_i[126:112];
  assign ub = {1'b0, ex} - 16'(Bias);

  always_comb begin
    d_d           = '0;
    d_d.vld       = vld_i;
    d_d.is_int    = req_type_i[1];
    d_d.away      = (req_type_i == REQ_AWAY) || (req_type_i == REQ_INT_AWY);
    d_d.mode      = rnd_mode_e'(mode_i);
    d_d.neg       = x_i[127];
    d_d.special   = (ex == ExpMax);
    d_d.tiny      = ({1'b0, ex} < 16'(Bias));
    d_d.near_half = ({1'b0, ex} == 16'(Bias - 1));
    d_d.big       = req_type_i[1] ? (!d_d.tiny && ub >= 16'd32)
                                  : (!d_d.tiny && ub >= 16'd112);
    d_d.frac_nz   = |x_i[111:0];
    d_d.exp_nz    = |ex;
    d_d.f         = 7'(16'd112 - ub);
    d_d.x         = x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= d_d.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  // valid bit comes from the reset register
  always_comb begin
    dec_o     = d_q;
    dec_o.vld = vld_q;
  end

  `QFR_ASSERT_NXT(a_vld_follows, clk_i, rst_ni, vld_i, dec_o.vld)
  `QFR_ASSERT_NXT(a_vld_idle, clk_i, rst_ni, !vld_i, !dec_o.vld)
  `QFR_ASSERT_IMP(a_cls_excl, clk_i, rst_ni, dec_o.vld && dec_o.special, !dec_o.tiny)
endmodule
`default_nettype wire

// ===== hw/rtl/qfr_align.sv =====
// ----------------------------------------------------------------------------
// qfr_align
// Stage 2: mask build, integer part shift, round bits.
// ----------------------------------------------------------------------------
`default_nettype none
module qfr_align (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  qfr_pkg::dec_t  dec_i,
  output qfr_pkg::mid_t  mid_o
);
  import qfr_pkg::*;
  `include "quad_float_round_to_integer_macros.svh"

  mid_t m_d, m_q;
  logic [48:0]  sh;
  logic [5:0]   s;      // 17..48 when in range
  logic [48:0]  ip;
  logic [48:0]  below;
  logic [127:0] ones;
  logic         vld_q;

  assign sh   = {1'b1, dec_i.x[111:64]};
  assign s    = 6'(dec_i.f - 7'd64);
  assign ip   = sh >> s;
  assign below = sh & ((49'd1 << (s - 6'd1)) - 49'd1);
  assign ones = (128'd1 << dec_i.f) - 128'd1;

  always_comb begin
    m_d          = '0;
    m_d.vld      = dec_i.vld;
    m_d.is_int   = dec_i.is_int;
    m_d.neg      = dec_i.neg;
    m_d.x        = dec_i.x;
    m_d.mode     = dec_i.mode;
    m_d.away     = dec_i.away;
    m_d.mask     = ~ones;
    m_d.addv     = dec_i.away ? (128'd1 << (dec_i.f - 7'd1)) : '0;
    m_d.inc      = dec_i.away;
    if (!dec_i.is_int) begin
      if (dec_i.special) begin
        m_d.pass = 1'b1;
        m_d.x[111] = dec_i.x[111] | dec_i.frac_nz;
      end else if (dec_i.tiny) begin
        m_d.zero_res = 1'b1;
        m_d.one_res  = dec_i.away && dec_i.near_half;
      end else if (dec_i.big) begin
        m_d.pass = 1'b1;
      end
    end else begin
      m_d.sat = dec_i.special || dec_i.big;
      if (dec_i.tiny) begin
        m_d.half   = dec_i.near_half;
        m_d.sticky = dec_i.near_half ? dec_i.frac_nz
                                     : (dec_i.frac_nz || dec_i.exp_nz);
      end else begin
        m_d.ipart  = 32'(ip);
        m_d.ip_big = 1'b0;
        m_d.half   = sh[s - 6'd1];
        m_d.sticky = (|below) || (|dec_i.x[63:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= m_d.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  always_comb begin
    mid_o     = m_q;
    mid_o.vld = vld_q;
  end

  `QFR_ASSERT_NXT(a_vld_follows, clk_i, rst_ni, dec_i.vld, mid_o.vld)
  `QFR_ASSERT_IMP(a_pass_float, clk_i, rst_ni, mid_o.vld && mid_o.pass, !mid_o.is_int)
  `QFR_ASSERT_IMP(a_one_zero, clk_i, rst_ni, mid_o.vld && mid_o.one_res, mid_o.zero_res)
endmodule
`default_nettype wire

// ===== hw/rtl/qfr_finish.sv =====
// ----------------------------------------------------------------------------
// qfr_finish
// Stage 3: add and mask, integer increment and saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module qfr_finish (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  qfr_pkg::mid_t     mid_i,
  output logic              done_o,
  output logic [63:0]       res_hi_o,
  output logic [63:0]       res_lo_o,
  output logic signed [31:0] int_result_o,
  output logic              out_of_range_o
);
  import qfr_pkg::*;
  `include "quad_float_round_to_integer_macros.svh"

  logic [127:0] fres, mag128;
  logic         inc;
  logic [32:0]  mag;
  logic         sat;
  logic [127:0] res_d;
  logic [31:0]  int_d;
  logic         oor_d;
  logic         done_q;
  logic [127:0] res_q;
  logic [31:0]  int_q;
  logic         oor_q;

  assign mag128 = ({1'b0, mid_i.x[126:0]} + mid_i.addv) & mid_i.mask;

  always_comb begin
    if (mid_i.pass) begin
      fres = mid_i.x;
    end else if (mid_i.zero_res) begin
      fres = {mid_i.neg, (mid_i.one_res ? 15'(Bias) : 15'd0), 112'd0};
    end else begin
      fres = {mid_i.neg, mag128[126:0]};
    end
  end

  always_comb begin
    if (mid_i.away) begin
      inc = mid_i.half;
    end else begin
      case (mid_i.mode)
        RM_RNE:  inc = mid_i.half && (mid_i.sticky || mid_i.ipart[0]);
        RM_RTZ:  inc = 1'b0;
        RM_RUP:  inc = (mid_i.half || mid_i.sticky) && !mid_i.neg;
        RM_RDN:  inc = (mid_i.half || mid_i.sticky) && mid_i.neg;
        default: inc = 1'b0;
      endcase
    end
  end

  assign mag = {1'b0, mid_i.ipart} + {32'd0, inc};
  assign sat = mid_i.sat ||
               (mid_i.neg ? (mag > 33'h080000000) : (mag > 33'h07fffffff));

  always_comb begin
    res_d = '0;
    int_d = '0;
    oor_d = 1'b0;
    if (mid_i.is_int) begin
      oor_d = sat;
      if (sat) begin
        int_d = mid_i.neg ? 32'h80000000 : 32'h7fffffff;
      end else begin
        int_d = mid_i.neg ? 32'(33'd0 - mag) : mag[31:0];
      end
    end else begin
      res_d = fres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mid_i.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    int_q <= int_d;
    oor_q <= oor_d;
  end

  assign done_o         = done_q;
  assign res_hi_o       = res_q[127:64];
  assign res_lo_o       = res_q[63:0];
  assign int_result_o   = int_q;
  assign out_of_range_o = oor_q;

  `QFR_ASSERT_NXT(a_done_follows, clk_i, rst_ni, mid_i.vld, done_o)
  `QFR_ASSERT_NXT(a_float_no_oor, clk_i, rst_ni, mid_i.vld && !mid_i.is_int,
                  !out_of_range_o && int_result_o == 32'd0)
  `QFR_ASSERT_NXT(a_int_no_res, clk_i, rst_ni, mid_i.vld && mid_i.is_int,
                  res_hi_o == 64'd0 && res_lo_o == 64'd0)
endmodule
`default_nettype wire

// ===== hw/rtl/quad_float_round_to_integer.sv =====
// ----------------------------------------------------------------------------
// quad_float_round_to_integer
// Binary128 round to integral value and round/convert to int32.
//
//  channel   signals                                         dir
//  request   start_i, busy_o, req_type_i, x_hi_i, x_lo_i     in (busy_o out)
//  result    done_o, res_hi_o, res_lo_o, int_result_o,
//            out_of_range_o                                  out
//  config    rounding_mode_we_i, rounding_mode_i             in
//
//  Three register stages: decode, align, finish.
//  One request per cycle; busy_o is always low, the pipe never stalls.
//  Result shows for one cycle with done_o. Reset clears valid bits and
//  sets the rounding mode to nearest even. Mode is sampled at issue.
// ----------------------------------------------------------------------------
`default_nettype none
module quad_float_round_to_integer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [63:0]       x_hi_i,
  input  wire logic [63:0]       x_lo_i,
  input  wire logic              rounding_mode_we_i,
  input  wire logic [1:0]        rounding_mode_i,
  output logic                   done_o,
  output logic [63:0]            res_hi_o,
  output logic [63:0]            res_lo_o,
  output logic signed [31:0]     int_result_o,
  output logic                   out_of_range_o
);
  import qfr_pkg::*;

  logic [1:0] mode_q;
  dec_t       dec;
  mid_t       mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RM_RNE;
    end else if (rounding_mode_we_i) begin
      mode_q <= rounding_mode_i;
    end
  end

  assign busy_o = 1'b0;

  qfr_decode u_dec (
    .clk_i, .rst_ni,
    .vld_i      (start_i),
    .req_type_i (req_type_i),
    .mode_i     (mode_q),
    .x_i        ({x_hi_i, x_lo_i}),
    .dec_o      (dec)
  );

  qfr_align u_aln (.clk_i, .rst_ni, .dec_i(dec), .mid_o(mid));

  qfr_finish u_fin (
    .clk_i, .rst_ni,
    .mid_i          (mid),
    .done_o         (done_o),
    .res_hi_o       (res_hi_o),
    .res_lo_o       (res_lo_o),
    .int_result_o   (int_result_o),
    .out_of_range_o (out_of_range_o)
  );
endmodule
`default_nettype wire
